// ===== hdl/mhpq_pkg.sv =====
// Shared types and codes of the min-heap priority queue.
// Used by mhpq_ctrl, mhpq_datapath and min_heap_priority_queue; no dependencies.
`timescale 1ns / 1ps

package mhpq_pkg;

  // Opcodes carried on the slave-side tuser
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_PEEK   = 2'd2;

  // Result status codes carried on the master-side tuser
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    DP_NOP,
    DP_INS_START,  // count up, hole at new last slot, latch value
    DP_UP_READ,    // read parent of hole
    DP_UP_STEP,    // move parent down or drop value into hole
    DP_PLACE,      // drop value into hole
    DP_RM_START,   // latch root as result, read last slot, count down
    DP_RM_LOAD,    // latch last entry as value, hole at root
    DP_DN_READ,    // read both children of hole
    DP_DN_STEP     // move smaller child up or drop value into hole
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic       out_load;  // load output payload
    logic       res_held;  // output latched minimum instead of current root
    logic [1:0] status;
  } dp_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_full;
    logic pos_root;
    logic up_less;   // value below its parent
    logic dn_leaf;   // hole has no child
    logic dn_done;   // value not above either child
  } dp_stat_t;

endpackage

// ===== hdl/mhpq_ctrl.sv =====
// Controller FSM of the min-heap priority queue: sequences insert, remove and peek.
// Depends on mhpq_pkg; drives mhpq_datapath through dp_cmd_t.
`timescale 1ns / 1ps

module mhpq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        opcode_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  mhpq_pkg::dp_stat_t stat_i,
  output mhpq_pkg::dp_cmd_t  cmd_o
);
  import mhpq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_UP_CMP,
    S_RM_LOAD,
    S_DN,
    S_DN_CMP,
    S_FIN
  } state_e;

  state_e     state_q;
  logic [1:0] status_q;
  logic       res_held_q;
  logic       out_valid_q;
  logic       out_load;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_load    = (state_q == S_FIN) && (!out_valid_q || out_ready_i);

  always_comb begin
    cmd_o          = '0;
    cmd_o.op       = DP_NOP;
    cmd_o.status   = status_q;
    cmd_o.res_held = res_held_q;
    cmd_o.out_load = out_load;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (opcode_i == OP_INSERT && !stat_i.cnt_full) begin
            cmd_o.op = DP_INS_START;
          end else if (opcode_i == OP_REMOVE && !stat_i.cnt_zero) begin
            cmd_o.op = DP_RM_START;
          end
        end
      end
      S_UP:      cmd_o.op = stat_i.pos_root ? DP_PLACE : DP_UP_READ;
      S_UP_CMP:  cmd_o.op = DP_UP_STEP;
      S_RM_LOAD: cmd_o.op = DP_RM_LOAD;
      S_DN:      cmd_o.op = stat_i.dn_leaf ? DP_PLACE : DP_DN_READ;
      S_DN_CMP:  cmd_o.op = DP_DN_STEP;
      S_FIN:     cmd_o.op = DP_NOP;
      default:   cmd_o.op = DP_NOP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      status_q    <= ST_DONE;
      res_held_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            status_q   <= ST_DONE;
            res_held_q <= 1'b0;
            priority if (opcode_i == OP_INSERT) begin
              if (stat_i.cnt_full) begin
                status_q <= ST_FULL;
                state_q  <= S_FIN;
              end else begin
                state_q <= S_UP;
              end
            end else if (opcode_i == OP_REMOVE) begin
              if (stat_i.cnt_zero) begin
                status_q <= ST_EMPTY;
                state_q  <= S_FIN;
              end else begin
                res_held_q <= 1'b1;
                state_q    <= S_RM_LOAD;
              end
            end else begin
              state_q <= S_FIN;  // peek, and the unused code
            end
          end
        end
        S_UP:      state_q <= stat_i.pos_root ? S_FIN : S_UP_CMP;
        S_UP_CMP:  state_q <= stat_i.up_less ? S_UP : S_FIN;
        S_RM_LOAD: state_q <= stat_i.cnt_zero ? S_FIN : S_DN;
        S_DN:      state_q <= stat_i.dn_leaf ? S_FIN : S_DN_CMP;
        S_DN_CMP:  state_q <= stat_i.dn_done ? S_FIN : S_DN;
        S_FIN: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default:   state_q <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_valid_i) |=> (state_q != S_IDLE))
    else $error("accepted item did not start work");
`endif

endmodule

// ===== hdl/mhpq_datapath.sv =====
// Datapath of the min-heap priority queue: heap memory, hole index, count, root copy, output.
// Depends on mhpq_pkg; commanded by mhpq_ctrl.
`timescale 1ns / 1ps

module mhpq_datapath #(
  parameter int CAPACITY   = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mhpq_pkg::dp_cmd_t  cmd_i,
  output mhpq_pkg::dp_stat_t stat_o,
  input  logic signed [31:0] insert_value_i,
  output logic signed [31:0] min_value_o,
  output logic [10:0]        entry_total_o,
  output logic [1:0]         status_o
);
  import mhpq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  typedef logic signed [DATA_WIDTH-1:0] val_t;

  // one-based heap store, slots 1..CAPACITY
  val_t mem [1:CAPACITY];

  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] pos_q;
  val_t          val_q, root_q, res_q;
  val_t          rd_a_q, rd_b_q;

  logic          rd_en;
  logic [CW-1:0] rd_addr_a, rd_addr_b;
  logic          wr_en;
  logic [CW-1:0] wr_addr;
  val_t          wr_data;

  logic [CW:0]   lidx, ridx, cnt_x;
  logic          l_ok, r_ok, take_l, take_r;
  val_t          best_val;
  logic [CW-1:0] parent;

  logic signed [63:0] ins_wide, root_wide, res_wide;
  val_t               ins_val;

  assign ins_wide  = 64'(insert_value_i);
  assign ins_val   = ins_wide[DATA_WIDTH-1:0];
  assign root_wide = 64'(root_q);
  assign res_wide  = 64'(res_q);

  assign parent   = pos_q >> 1;
  assign lidx     = {pos_q, 1'b0};
  assign ridx     = {pos_q, 1'b1};
  assign cnt_x    = {1'b0, cnt_q};
  assign l_ok     = (lidx <= cnt_x);
  assign r_ok     = (ridx <= cnt_x);
  // left child wins ties
  assign take_l   = (rd_a_q < val_q);
  assign best_val = take_l ? rd_a_q : val_q;
  assign take_r   = r_ok && (rd_b_q < best_val);

  assign stat_o.cnt_zero = (cnt_q == '0);
  assign stat_o.cnt_full = (cnt_q == CW'(CAPACITY));
  assign stat_o.pos_root = (pos_q == CW'(1));
  assign stat_o.up_less  = (val_q < rd_a_q);
  assign stat_o.dn_leaf  = !l_ok;
  assign stat_o.dn_done  = !take_l && !take_r;

  always_comb begin
    rd_en     = 1'b0;
    rd_addr_a = pos_q;
    rd_addr_b = pos_q;
    wr_en     = 1'b0;
    wr_addr   = pos_q;
    wr_data   = val_q;
    cnt_d     = cnt_q;
    unique case (cmd_i.op)
      DP_INS_START: cnt_d = cnt_q + CW'(1);
      DP_UP_READ: begin
        rd_en     = 1'b1;
        rd_addr_a = parent;
      end
      DP_UP_STEP: begin
        wr_en   = 1'b1;
        wr_data = stat_o.up_less ? rd_a_q : val_q;
      end
      DP_PLACE: wr_en = 1'b1;
      DP_RM_START: begin
        rd_en     = 1'b1;
        rd_addr_a = cnt_q;
        cnt_d     = cnt_q - CW'(1);
      end
      DP_DN_READ: begin
        rd_en     = 1'b1;
        rd_addr_a = lidx[CW-1:0];
        rd_addr_b = r_ok ? ridx[CW-1:0] : lidx[CW-1:0];
      end
      DP_DN_STEP: begin
        wr_en = 1'b1;
        priority if (take_r) begin
          wr_data = rd_b_q;
        end else if (take_l) begin
          wr_data = rd_a_q;
        end else begin
          wr_data = val_q;
        end
      end
      DP_NOP, DP_RM_LOAD: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // heap memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_q <= mem[rd_addr_a];
      rd_b_q <= mem[rd_addr_b];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en && wr_addr == CW'(1)) begin
      root_q <= wr_data;
    end
    unique case (cmd_i.op)
      DP_INS_START: begin
        pos_q <= cnt_q + CW'(1);
        val_q <= ins_val;
      end
      DP_UP_STEP: begin
        if (stat_o.up_less) begin
          pos_q <= parent;
        end
      end
      DP_RM_START: res_q <= root_q;
      DP_RM_LOAD: begin
        val_q <= rd_a_q;
        pos_q <= CW'(1);
      end
      DP_DN_STEP: begin
        priority if (take_r) begin
          pos_q <= ridx[CW-1:0];
        end else if (take_l) begin
          pos_q <= lidx[CW-1:0];
        end
      end
      DP_NOP, DP_UP_READ, DP_PLACE, DP_DN_READ: ;
      default: ;
    endcase
    if (cmd_i.out_load) begin
      priority if (cmd_i.res_held) begin
        min_value_o <= res_wide[31:0];
      end else if (cnt_q == '0) begin
        min_value_o <= '0;
      end else begin
        min_value_o <= root_wide[31:0];
      end
      entry_total_o <= 11'(cnt_q);
      status_o      <= cmd_i.status;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("entry count above capacity");
  a_wr_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (wr_addr != '0 && wr_addr <= cnt_q))
    else $error("write outside occupied slots");
  a_ins_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == DP_INS_START) |=> (cnt_q == $past(cnt_q) + CW'(1)))
    else $error("insert did not grow count");
`endif

endmodule

// ===== hdl/min_heap_priority_queue.sv =====
// Binary min-heap priority queue of signed values: top level, stream ports.
// Depends on mhpq_pkg, mhpq_ctrl and mhpq_datapath.
// Each item is insert, remove-minimum or peek; each gives exactly one result item holding
// the root (removed minimum for a remove, 0 when nothing is held), the entry count after the
// operation and a status (done, insert refused because full, remove refused because empty).
// The heap lives in a one-based memory with one write port and two registered read ports;
// a root copy in flops serves peeks and results without a read. Items are processed one at
// a time. An insert climbs its value from the new last slot while it is below its parent;
// a remove moves the last entry to the root and sinks it toward its smaller child. Each
// level moved takes a memory read and then a compare-and-write; at CAPACITY 1024 a value
// moves at most ten levels. The result sits in an output register, so the next item is
// accepted while a result still waits to be taken; an item that finishes while that
// register is still full holds in its final state until the waiting result is taken. The
// store needs no clearing after reset: only slots 1 up to the entry count are ever read.
`timescale 1ns / 1ps

module min_heap_priority_queue #(
  parameter int CAPACITY   = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] insert_value
  input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [31:0] min_value, [42:32] entry_total, rest zero
  output logic [1:0]  m_axis_tuser    // [1:0] status
);
  import mhpq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  logic signed [31:0] min_value;
  logic [10:0]        entry_total;

  mhpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .opcode_i    (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  mhpq_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .insert_value_i (s_axis_tdata),
    .min_value_o    (min_value),
    .entry_total_o  (entry_total),
    .status_o       (m_axis_tuser)
  );

  assign m_axis_tdata = {5'd0, entry_total, min_value};

endmodule

// ===== tb/mhpq_checker.sv =====
// Result checker for the min-heap priority queue: watches both stream channels,
// keeps a shadow heap and compares every result item. Depends on mhpq_pkg.
`timescale 1ns / 1ps

module mhpq_checker #(
  parameter int CAPACITY = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [31:0] in_data_i,    // [31:0] insert_value
  input  logic [1:0]  in_user_i,    // [1:0] opcode
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [47:0] out_data_i,   // [31:0] min_value, [42:32] entry_total
  input  logic [1:0]  out_user_i,   // [1:0] status
  output int          fail_count_o,
  output int          pending_o
);
  import mhpq_pkg::*;

  typedef struct packed {
    logic signed [31:0] min_value;
    logic [10:0]        entry_total;
    logic [1:0]         status;
  } heap_result_t;

  logic signed [31:0] shadow_heap [1:CAPACITY];
  int unsigned        shadow_count = 0;
  heap_result_t       pending_results [$];

  // Applies one operation to the shadow heap and returns the result it gives.
  function automatic heap_result_t heap_apply(input logic [1:0] op,
                                              input logic signed [31:0] value);
    heap_result_t       res;
    int unsigned        pos;
    int unsigned        best;
    int unsigned        lchild;
    int unsigned        rchild;
    logic signed [31:0] tmp;
    bit                 settled;
    res.min_value = '0;
    res.status    = ST_DONE;
    case (op)
      OP_INSERT: begin
        if (shadow_count >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          shadow_count++;
          shadow_heap[shadow_count] = value;
          pos = shadow_count;
          // climb while strictly below the parent
          while (pos > 1 && shadow_heap[pos] < shadow_heap[pos / 2]) begin
            tmp                   = shadow_heap[pos];
            shadow_heap[pos]      = shadow_heap[pos / 2];
            shadow_heap[pos / 2]  = tmp;
            pos                   = pos / 2;
          end
        end
        if (shadow_count > 0) res.min_value = shadow_heap[1];
      end
      OP_REMOVE: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.min_value  = shadow_heap[1];
          shadow_heap[1] = shadow_heap[shadow_count];
          shadow_count--;
          pos     = 1;
          settled = 1'b0;
          // descend toward the smaller child, left child on a tie
          while (!settled) begin
            best   = pos;
            lchild = 2 * pos;
            rchild = lchild + 1;
            if (lchild <= shadow_count && shadow_heap[lchild] < shadow_heap[best])
              best = lchild;
            if (rchild <= shadow_count && shadow_heap[rchild] < shadow_heap[best])
              best = rchild;
            if (best == pos) begin
              settled = 1'b1;
            end else begin
              tmp               = shadow_heap[pos];
              shadow_heap[pos]  = shadow_heap[best];
              shadow_heap[best] = tmp;
              pos               = best;
            end
          end
        end
      end
      default: begin
        // peek, and the unused opcode which behaves as one
        if (shadow_count > 0) res.min_value = shadow_heap[1];
      end
    endcase
    res.entry_total = 11'(shadow_count);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_count = 0;
      pending_results.delete();
      pending_o    = 0;
      fail_count_o = 0;
    end else begin : sample
      heap_result_t want;
      heap_result_t got;
      // results first: a result never belongs to an item taken in the same cycle
      if (out_valid_i && out_ready_i) begin
        got.min_value   = out_data_i[31:0];
        got.entry_total = out_data_i[42:32];
        got.status      = out_user_i;
        if (pending_results.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: result with no item pending: min_value %0d entry_total %0d status %0d",
                     $realtime, $signed(got.min_value), got.entry_total, got.status);
        end else begin
          want = pending_results.pop_front();
          if (got.min_value !== want.min_value || got.entry_total !== want.entry_total ||
              got.status !== want.status) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display({"%0t: result mismatch: min_value exp %0d got %0d, ",
                        "entry_total exp %0d got %0d, status exp %0d got %0d"},
                       $realtime, $signed(want.min_value), $signed(got.min_value),
                       want.entry_total, got.entry_total, want.status, got.status);
          end
        end
      end
      if (in_valid_i && in_ready_i)
        pending_results.push_back(heap_apply(in_user_i, $signed(in_data_i)));
      pending_o = pending_results.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Top of the min-heap priority queue testbench: clock, reset, item stimulus,
// output back-pressure and the verdict. Depends on mhpq_pkg, mhpq_checker and the RTL.
`timescale 1ns / 1ps

module tb_top;
  import mhpq_pkg::*;

  localparam int CAPACITY        = 1024;
  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 9;
  localparam int RANDOM_ITEMS    = 2000;
  localparam int PHASE_ITEMS     = 500;      // random items per idling phase
  localparam int PRESSURE_CYCLES = 300;      // long hold-off on the output
  localparam int PRESSURE_ITEMS  = 12;
  localparam int TAIL_CYCLES     = 40;       // wait after all results are taken, for stray outputs
  localparam int LIMIT_CYCLES    = 1_000_000;

  // opcode with no meaning of its own; the block treats it as a peek
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [31:0] insert_value
  logic [1:0]  s_axis_tuser;   // [1:0] opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // [31:0] min_value, [42:32] entry_total, rest zero
  logic [1:0]  m_axis_tuser;   // [1:0] status

  int   fail_count;
  int   pending;

  // idling knobs, in percent of cycles
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;

  logic press_start = 1'b0;
  logic hold_off    = 1'b0;
  int   cycle_cnt   = 0;

  // entry count as seen by the stimulus, only used to steer fill and drain
  int   level = 0;

  min_heap_priority_queue #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (32)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  mhpq_checker #(
    .CAPACITY (CAPACITY)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .in_user_i    (s_axis_tuser),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .out_user_i   (m_axis_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Run-away guard.
  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= LIMIT_CYCLES);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Output side: random stalls per cycle, forced low while the hold-off runs.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      m_axis_tready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Long hold-off counted here; the sender keeps offering items meanwhile, so the
  // output register fills, the next item gets taken, and then tready drops.
  initial begin
    wait (press_start);
    hold_off <= 1'b1;
    repeat (PRESSURE_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // Offers one item after a random gap and returns at the edge that takes it.
  // tvalid stays high into the next item when no gap is drawn.
  task automatic send_item(input logic [1:0] op, input logic [31:0] value);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= $urandom;
      s_axis_tuser  <= 2'($urandom);
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    if (op == OP_INSERT && level < CAPACITY) level++;
    else if (op == OP_REMOVE && level > 0) level--;
  endtask

  // Mostly full-range values; some extremes, some tight values to force ties.
  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       v = 32'h7fff_ffff;
          1:       v = 32'h8000_0000;
          2:       v = 32'h0000_0000;
          default: v = 32'hffff_ffff;
        endcase
      end
      1, 2:    v = 32'($signed($urandom_range(0, 15)) - 8);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  initial begin : stimulus
    int         rand_sent;
    int         roll;
    bit         filling;
    bit         been_full;
    bit         cycle_done;
    logic [1:0] op;

    rand_sent  = 0;
    filling    = 1'b1;
    been_full  = 1'b0;
    cycle_done = 1'b0;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_PEEK;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty-heap cases, extremes, ties, drain past empty
    send_item(OP_PEEK,   32'h0);
    send_item(OP_REMOVE, 32'hffff_ffff);   // value must be ignored
    send_item(OP_UNUSED, 32'h0);           // unused opcode acts as a peek
    send_item(OP_INSERT, 32'h7fff_ffff);
    send_item(OP_INSERT, 32'h8000_0000);
    send_item(OP_INSERT, 32'h0000_0000);
    send_item(OP_INSERT, 32'hffff_ffff);
    send_item(OP_INSERT, 32'd5);
    send_item(OP_INSERT, 32'd5);
    send_item(OP_INSERT, 32'd5);
    send_item(OP_PEEK,   32'h1234_5678);
    send_item(OP_UNUSED, 32'h0);
    repeat (8) send_item(OP_REMOVE, 32'h0);   // last one hits an empty heap
    send_item(OP_INSERT, 32'haaaa_aaaa);
    send_item(OP_INSERT, 32'h5555_5555);
    send_item(OP_REMOVE, 32'h0);
    send_item(OP_REMOVE, 32'h0);

    // back-pressure burst with no input gaps
    press_start <= 1'b1;
    repeat (PRESSURE_ITEMS) send_item(2'($urandom_range(0, 2)), pick_value());

    // random: fill to capacity (refused inserts at the top), then drain to empty
    // (refused removes at the bottom); keeps going until one full cycle is done
    while (rand_sent < RANDOM_ITEMS || !cycle_done) begin
      case ((rand_sent / PHASE_ITEMS) % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < 96)      op = filling ? OP_INSERT : OP_REMOVE;
      else if (roll < 97) op = filling ? OP_REMOVE : OP_INSERT;
      else if (roll < 99) op = OP_PEEK;
      else                op = OP_UNUSED;
      send_item(op, pick_value());
      rand_sent++;
      if (filling && level == CAPACITY) begin
        been_full = 1'b1;
        if ($urandom_range(0, 19) == 0) filling = 1'b0;
      end else if (!filling && level == 0 && $urandom_range(0, 9) == 0) begin
        filling = 1'b1;
        if (been_full) cycle_done = 1'b1;
      end
    end
    s_axis_tvalid <= 1'b0;

    // let every result drain, then a little extra for stray outputs
    do @(posedge clk_i); while (pending != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    // results still owed count as failures
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
